>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; every macro samples on the rising edge of clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/iol_pkg.sv
// types and codes for the identifier and operator lexer
// no dependencies; used by every module
package iol_pkg;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;
   localparam logic [1:0] MODE_EQ    = 2'd2;
   localparam logic [1:0] MODE_MINUS = 2'd3;

   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_IDENT_END = 2'd1;
   localparam logic [1:0] KIND_OP        = 2'd2;
   localparam logic [1:0] KIND_EOI       = 2'd3;

   localparam logic [2:0] OP_COLON  = 3'd0;
   localparam logic [2:0] OP_DOT    = 3'd1;
   localparam logic [2:0] OP_COMMA  = 3'd2;
   localparam logic [2:0] OP_EQ1    = 3'd3;
   localparam logic [2:0] OP_EQ2    = 3'd4;
   localparam logic [2:0] OP_MINUS1 = 3'd5;
   localparam logic [2:0] OP_MINUS2 = 3'd6;
   localparam logic [2:0] OP_MINUS3 = 3'd7;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_COLON   = 8'h3a;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_COMMA   = 8'h2c;
   localparam logic [7:0] CH_EQUALS  = 8'h3d;
   localparam logic [7:0] CH_MINUS   = 8'h2d;

   localparam logic [7:0] IDENT_MAX = 8'd255;

   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] ch;
      logic       at_end;
   } item_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] run_count;
      logic [7:0] ident_count;
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [2:0] op;
      logic [7:0] ident_length;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } core_out_type;

endpackage

>>> sv/iol_req_if.sv
// request channel: one source byte or end-of-input mark per beat
// depends on nothing
interface iol_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       at_end;

   modport source (output valid, output ch, output at_end, input ready);
   modport sink (input valid, input ch, input at_end, output ready);
endinterface

>>> sv/iol_rsp_if.sv
// response channel: one token per beat
// depends on nothing
interface iol_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_out;
   logic [2:0] op;
   logic [7:0] ident_length;
   logic       last;

   modport source (output valid, output kind, output char_out, output op,
                   output ident_length, output last, input ready);
   modport sink (input valid, input kind, input char_out, input op,
                 input ident_length, input last, output ready);
endinterface

>>> sv/iol_core.sv
// lexer step: next state and up to two tokens for one item
// combinational; depends on iol_pkg
module iol_core import iol_pkg::*; (
   input  item_type     item,
   input  state_type    state,
   output state_type    state_next,
   output core_out_type result
);

   typedef struct packed {
      logic       emit;
      result_type res;
      state_type  st;
   } idle_type;

   function automatic result_type make_res(logic [1:0] kind, logic [7:0] c,
                                           logic [2:0] op, logic [7:0] len);
      result_type r;
      r.kind = kind;
      r.char_out = c;
      r.op = op;
      r.ident_length = len;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic logic is_delim(logic [7:0] c);
      return c == CH_SPACE || c == CH_NEWLINE || c == CH_COLON || c == CH_DOT ||
             c == CH_COMMA || c == CH_EQUALS || c == CH_MINUS;
   endfunction

   function automatic logic [2:0] run_op(logic [1:0] mode, logic [1:0] run);
      logic [1:0] rc;
      logic [2:0] op;
      rc = (run == 2'd0) ? 2'd1 : run;
      if (mode == MODE_EQ) begin
         op = (rc == 2'd1) ? OP_EQ1 : OP_EQ2;
      end else begin
         unique case (rc)
            2'd1:    op = OP_MINUS1;
            2'd2:    op = OP_MINUS2;
            default: op = OP_MINUS3;
         endcase
      end
      return op;
   endfunction

   function automatic idle_type handle_idle(logic [7:0] c);
      idle_type h;
      h.emit = 1'b0;
      h.res = make_res(KIND_CHAR, c, OP_COLON, 8'd0);
      h.st.mode = MODE_IDLE;
      h.st.run_count = 2'd0;
      h.st.ident_count = 8'd0;
      priority if (c == CH_SPACE || c == CH_NEWLINE) begin
         h.emit = 1'b0;
      end else if (c == CH_COLON) begin
         h.emit = 1'b1;
         h.res = make_res(KIND_OP, 8'd0, OP_COLON, 8'd0);
      end else if (c == CH_DOT) begin
         h.emit = 1'b1;
         h.res = make_res(KIND_OP, 8'd0, OP_DOT, 8'd0);
      end else if (c == CH_COMMA) begin
         h.emit = 1'b1;
         h.res = make_res(KIND_OP, 8'd0, OP_COMMA, 8'd0);
      end else if (c == CH_EQUALS) begin
         h.st.mode = MODE_EQ;
         h.st.run_count = 2'd1;
      end else if (c == CH_MINUS) begin
         h.st.mode = MODE_MINUS;
         h.st.run_count = 2'd1;
      end else begin
         h.emit = 1'b1;
         h.st.mode = MODE_IDENT;
         h.st.ident_count = 8'd1;
      end
      return h;
   endfunction

   idle_type   idle;
   result_type eoi_res;
   result_type end_res;
   result_type run_res;
   logic [7:0] want;
   logic [1:0] run_max;
   logic [1:0] run_inc;
   logic [1:0] count;
   result_type res0;
   result_type res1;

   assign idle = handle_idle(item.ch);
   assign eoi_res = make_res(KIND_EOI, 8'd0, OP_COLON, 8'd0);
   assign end_res = make_res(KIND_IDENT_END, 8'd0, OP_COLON, state.ident_count);
   assign run_res = make_res(KIND_OP, 8'd0, run_op(state.mode, state.run_count), 8'd0);
   assign want = (state.mode == MODE_EQ) ? CH_EQUALS : CH_MINUS;
   assign run_max = (state.mode == MODE_EQ) ? 2'd2 : 2'd3;
   assign run_inc = state.run_count + 2'd1;

   always_comb begin
      state_next = state;
      count = COUNT_NONE;
      res0 = eoi_res;
      res1 = eoi_res;
      priority if (item.at_end) begin
         state_next = '0;
         unique case (state.mode)
            MODE_IDENT: begin
               res0 = end_res;
               count = COUNT_TWO;
            end
            MODE_EQ, MODE_MINUS: begin
               res0 = run_res;
               count = COUNT_TWO;
            end
            default: begin
               count = COUNT_ONE;
            end
         endcase
      end else if (item.ch == CH_NUL) begin
         count = COUNT_NONE;
      end else if (state.mode == MODE_IDENT) begin
         if (is_delim(item.ch)) begin
            res0 = end_res;
            res1 = idle.res;
            count = idle.emit ? COUNT_TWO : COUNT_ONE;
            state_next = idle.st;
         end else begin
            res0 = make_res(KIND_CHAR, item.ch, OP_COLON, 8'd0);
            count = COUNT_ONE;
            if (state.ident_count != IDENT_MAX) begin
               state_next.ident_count = state.ident_count + 8'd1;
            end
         end
      end else if (state.mode == MODE_EQ || state.mode == MODE_MINUS) begin
         if (item.ch == want) begin
            if (run_inc >= run_max || run_inc == 2'd0) begin
               res0 = make_res(KIND_OP, 8'd0, run_op(state.mode, run_max), 8'd0);
               count = COUNT_ONE;
               state_next.mode = MODE_IDLE;
               state_next.run_count = 2'd0;
            end else begin
               state_next.run_count = run_inc;
            end
         end else begin
            res0 = run_res;
            res1 = idle.res;
            count = idle.emit ? COUNT_TWO : COUNT_ONE;
            state_next = idle.st;
         end
      end else begin
         res0 = idle.res;
         count = idle.emit ? COUNT_ONE : COUNT_NONE;
         state_next = idle.st;
      end
      res0.last = (count == COUNT_ONE);
      res1.last = 1'b1;
   end

   assign result.count = count;
   assign result.res0 = res0;
   assign result.res1 = res1;

endmodule

>>> sv/iol_out_buf.sv
// two-entry token buffer that drives the response channel
// depends on iol_pkg and iol_rsp_if
module iol_out_buf import iol_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  core_out_type  result,
   output logic          load_ok,
   iol_rsp_if.source     rsp_chan
);

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       v0_ff, v0_in;
   logic       v1_ff, v1_in;
   result_type shown;
   logic       fire;

   assign shown = v0_ff ? slot0_ff : slot1_ff;
   assign rsp_chan.valid = v0_ff | v1_ff;
   assign rsp_chan.kind = shown.kind;
   assign rsp_chan.char_out = shown.char_out;
   assign rsp_chan.op = shown.op;
   assign rsp_chan.ident_length = shown.ident_length;
   assign rsp_chan.last = shown.last;

   assign fire = rsp_chan.valid & rsp_chan.ready;
   assign load_ok = !(v0_ff | v1_ff) | (fire & !(v0_ff & v1_ff));

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      if (load) begin
         slot0_in = result.res0;
         slot1_in = result.res1;
         unique case (result.count)
            COUNT_ONE: begin
               v0_in = 1'b1;
               v1_in = 1'b0;
            end
            COUNT_TWO: begin
               v0_in = 1'b1;
               v1_in = 1'b1;
            end
            default: begin
               v0_in = 1'b0;
               v1_in = 1'b0;
            end
         endcase
      end else if (fire) begin
         if (v0_ff) begin
            v0_in = 1'b0;
         end else begin
            v1_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

>>> sv/identifier_operator_lexer_top.sv
// top level of the identifier and operator lexer
// depends on iol_pkg, iol_req_if, iol_rsp_if, iol_core, iol_out_buf, assert_macros.svh
//
// usage:
//   req_chan carries one source byte (ch) or an end-of-input mark (at_end)
//   per beat; rsp_chan carries tokens, and last marks the final token that
//   one request beat produced. a request beat gives zero, one or two tokens.
//   a request beat is registered in the input register at its handshake,
//   and its tokens are loaded into the output buffer once the buffer can
//   take them. one request is taken per cycle while each gives at most
//   one token and rsp_chan.ready stays high; a beat with two tokens holds
//   the request side until its second token is taken, since the response
//   side moves one token per cycle. the limit is the single token per
//   cycle of the two-entry output buffer.
//   reset clears the lexer state to idle, empties the input register and
//   the output buffer; nothing else needs clearing.
//   when the receiver stalls, tokens wait in the output buffer and one more
//   request beat waits in the input register; after that req_chan.ready
//   drops until the buffer drains.
`include "assert_macros.svh"

module identifier_operator_lexer_top import iol_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   iol_req_if.sink   req_chan,
   iol_rsp_if.source rsp_chan
);

   item_type     in_ff, in_in;
   logic         in_valid_ff, in_valid_in;
   state_type    state_ff, state_in;
   state_type    state_next;
   core_out_type result;
   logic         load_ok;
   logic         advance;
   logic         req_fire;

   assign advance = in_valid_ff & load_ok;
   assign req_chan.ready = !in_valid_ff | load_ok;
   assign req_fire = req_chan.valid & req_chan.ready;

   always_comb begin
      in_in = in_ff;
      in_valid_in = in_valid_ff;
      state_in = state_ff;
      if (req_fire) begin
         in_in.ch = req_chan.ch;
         in_in.at_end = req_chan.at_end;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
      end
      in_ff <= in_in;
   end

   iol_core u_core (
      .item       (in_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   iol_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .load_ok  (load_ok),
      .rsp_chan (rsp_chan)
   );

   `ASSERT_NEXT(a_eoi_resets, clock, reset, advance && in_ff.at_end,
      state_ff.mode == MODE_IDLE && state_ff.ident_count == 8'd0,
      "state not cleared after end of input")
   `ASSERT_IMPLY(a_run_nonzero, clock, reset,
      state_ff.mode == MODE_EQ || state_ff.mode == MODE_MINUS,
      state_ff.run_count != 2'd0, "operator run with zero count")
   `ASSERT_IMPLY(a_idle_run_zero, clock, reset, state_ff.mode == MODE_IDLE,
      state_ff.run_count == 2'd0, "idle mode with open run count")

endmodule
